// ===== rtl/lkv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 31;
    localparam int CFG_W       = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic signed [KEY_W-1:0] lookup_key;
        logic        [VAL_W-1:0] write_value;
    } t_in_word;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic             evicted;
    } t_out_word;

    // broadcast to every cell
    typedef struct packed {
        logic             hit_load;
        logic             put_miss;
        logic             evict;
        logic [KEY_W-1:0] key;
    } t_cell_cmd;

    // reported by every cell
    typedef struct packed {
        logic             hit;
        logic             full;
        logic [VAL_W-1:0] hit_value;
    } t_cell_stat;

endpackage
`default_nettype wire

// ===== rtl/lkv_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_cell
// One recency slot: holds key, value and valid, compares against the
// incoming key and shifts in its upper neighbor's entry on update.
// ----------------------------------------------------------------------------
module lkv_cell #(
    parameter int INDEX = 0,
    parameter int CAP_W = 5
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire  lkv_pkg::t_cell_cmd  i_cmd,
    input  wire  [CAP_W-1:0]          i_cap,
    input  wire  [lkv_pkg::KEY_W-1:0] i_prev_key,
    input  wire  [lkv_pkg::VAL_W-1:0] i_prev_value,
    input  wire                       i_prev_valid,
    input  wire                       i_hit_below,
    output logic                      o_hit_below,
    output logic [lkv_pkg::KEY_W-1:0] o_key,
    output logic [lkv_pkg::VAL_W-1:0] o_value,
    output logic                      o_valid,
    output lkv_pkg::t_cell_stat       o_stat
);
    import lkv_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic             r_valid;
    logic             w_hit;
    logic             w_beyond;
    logic             w_last_or_beyond;
    logic             w_shift;
    logic             w_kill;

    assign w_hit            = r_valid && (r_key == i_cmd.key);
    assign w_beyond         = INDEX >= int'(i_cap);
    assign w_last_or_beyond = (INDEX + 1) >= int'(i_cap);

    assign w_shift = (i_cmd.hit_load && !i_hit_below) ||
                     (i_cmd.put_miss && !(i_cmd.evict && w_beyond));
    assign w_kill  = i_cmd.put_miss && i_cmd.evict && w_beyond;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_prev_valid;
        end else if (w_kill) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

    assign o_hit_below      = i_hit_below || w_hit;
    assign o_key            = r_key;
    assign o_value          = r_value;
    assign o_valid          = r_valid;
    assign o_stat.hit       = w_hit;
    assign o_stat.full      = r_valid && w_last_or_beyond;
    assign o_stat.hit_value = w_hit ? r_value : '0;

endmodule
`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each input word is a get or a put; each produces one output word. Entries
// sit in a chain of cells in recency order, cell 0 most recent. All cells
// compare the key in parallel and the chain shifts in the same cycle, so a
// word is taken every cycle; the result lands in an output register in the
// cycle after acceptance, and input is taken while that register is empty or
// being read. The capacity register is clamped to 1..ENTRIES and takes
// effect on the next put of a new key. The cache is empty after reset.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_ready,
    input  wire  lkv_pkg::t_in_word   i_in_word,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output lkv_pkg::t_out_word        o_out_word,
    input  wire                       i_cfg_we,
    input  wire  [lkv_pkg::CFG_W-1:0] i_cfg_data
);
    import lkv_pkg::*;

    localparam int CAP_W = $clog2(ENTRIES + 1);

    logic [CFG_W-1:0] r_cap;
    logic [CAP_W-1:0] w_cap;
    logic             r_out_valid;
    t_out_word        r_out;
    t_out_word        n_out;
    logic             w_accept;
    logic             w_found;
    logic             w_evict;
    logic [VAL_W-1:0] w_hit_value;
    t_cell_cmd        w_cmd;

    logic [KEY_W-1:0] w_key   [ENTRIES+1];
    logic [VAL_W-1:0] w_value [ENTRIES+1];
    logic             w_valid [ENTRIES+1];
    logic [ENTRIES:0] w_hit_below;
    t_cell_stat       w_stat  [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_cap == '0) begin
            w_cap = CAP_W'(1);
        end else if (int'(r_cap) > ENTRIES) begin
            w_cap = CAP_W'(ENTRIES);
        end else begin
            w_cap = CAP_W'(r_cap);
        end
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_found     = 1'b0;
        w_evict     = 1'b0;
        w_hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_found     = w_found | w_stat[i].hit;
            w_evict     = w_evict | w_stat[i].full;
            w_hit_value = w_hit_value | w_stat[i].hit_value;
        end
    end

    assign w_cmd.hit_load = w_accept && w_found;
    assign w_cmd.put_miss = w_accept && !w_found && (i_in_word.opcode == OP_PUT);
    assign w_cmd.evict    = w_evict;
    assign w_cmd.key      = i_in_word.lookup_key;

    // front of chain: entry becoming most recent
    assign w_key[0]       = i_in_word.lookup_key;
    assign w_value[0]     = (i_in_word.opcode == OP_GET) ? w_hit_value
                                                         : i_in_word.write_value;
    assign w_valid[0]     = 1'b1;
    assign w_hit_below[0] = 1'b0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkv_cell #(
            .INDEX (g),
            .CAP_W (CAP_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_cap        (w_cap),
            .i_prev_key   (w_key[g]),
            .i_prev_value (w_value[g]),
            .i_prev_valid (w_valid[g]),
            .i_hit_below  (w_hit_below[g]),
            .o_hit_below  (w_hit_below[g+1]),
            .o_key        (w_key[g+1]),
            .o_value      (w_value[g+1]),
            .o_valid      (w_valid[g+1]),
            .o_stat       (w_stat[g])
        );
    end

    always_comb begin
        n_out.found      = w_found;
        n_out.read_value = (w_found && (i_in_word.opcode == OP_GET)) ? w_hit_value : '0;
        n_out.evicted    = !w_found && (i_in_word.opcode == OP_PUT) && w_evict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
`default_nettype wire

// ===== tb/lkv_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lkv_checker
// Scoreboard for the LRU key-value cache. It watches the request, response
// and capacity ports, keeps its own recency-ordered copy of the cache
// contents, queues the predicted response for every accepted request word,
// and compares each accepted response word against the oldest prediction.
// ----------------------------------------------------------------------------
module lkv_checker #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    input  wire                       i_in_ready,
    input  lkv_pkg::t_in_word         i_in_word,
    input  wire                       i_out_valid,
    input  wire                       i_out_ready,
    input  lkv_pkg::t_out_word        i_out_word,
    input  wire                       i_cfg_we,
    input  wire  [lkv_pkg::CFG_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    import lkv_pkg::*;

    logic [KEY_W-1:0] line_key [ENTRIES];
    logic [VAL_W-1:0] line_val [ENTRIES];
    bit               line_live [ENTRIES];
    logic [CFG_W-1:0] capacity;
    t_out_word        response_q [$];
    int               mismatches = 0;
    int               waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // one request against the cache copy; updates recency order in place
    function automatic t_out_word serve_request(input t_in_word w);
        t_out_word        r;
        int               hit_at;
        int               fill;
        int               cap;
        int               pos;
        logic [VAL_W-1:0] v;
        r      = '0;
        hit_at = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit_at < 0 && line_live[i] && line_key[i] == w.lookup_key)
                hit_at = i;
        end
        if (hit_at >= 0) begin
            r.found = 1'b1;
            if (w.opcode == OP_GET) begin
                r.read_value = line_val[hit_at];
                v = line_val[hit_at];
            end else begin
                v = w.write_value;
            end
            pos = hit_at;
        end else if (w.opcode == OP_PUT) begin
            fill = 0;
            for (int i = 0; i < ENTRIES; i++)
                if (line_live[i]) fill++;
            cap = capacity;
            if (cap < 1) cap = 1;
            if (cap > ENTRIES) cap = ENTRIES;
            if (fill >= cap) begin
                r.evicted = 1'b1;
                for (int i = cap - 1; i < ENTRIES; i++)
                    line_live[i] = 1'b0;
                fill = cap - 1;
            end
            v   = w.write_value;
            pos = fill;
        end else begin
            return r;
        end
        if (pos >= ENTRIES) pos = ENTRIES - 1;
        for (int i = pos; i > 0; i--) begin
            line_key[i]  = line_key[i-1];
            line_val[i]  = line_val[i-1];
            line_live[i] = line_live[i-1];
        end
        line_key[0]  = w.lookup_key;
        line_val[0]  = v;
        line_live[0] = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word due;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++)
                line_live[i] = 1'b0;
            capacity = CAP_RESET;
            response_q.delete();
            waiting <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (response_q.size() == 0) begin
                    report_mismatch("response word with none outstanding");
                end else begin
                    due = response_q.pop_front();
                    if (i_out_word.found !== due.found)
                        report_mismatch($sformatf("found got %0b want %0b",
                            i_out_word.found, due.found));
                    if (i_out_word.read_value !== due.read_value)
                        report_mismatch($sformatf("read_value got %h want %h",
                            i_out_word.read_value, due.read_value));
                    if (i_out_word.evicted !== due.evicted)
                        report_mismatch($sformatf("evicted got %0b want %0b",
                            i_out_word.evicted, due.evicted));
                end
            end
            if (i_in_valid && i_in_ready)
                response_q.push_back(serve_request(i_in_word));
            if (i_cfg_we)
                capacity = i_cfg_data;
            waiting <= response_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the LRU key-value cache. Directed gets and puts cover empty
// misses, extreme keys and values, overwrites and a zero capacity;
// random phases then sweep the capacity register while drawing keys from a
// small pool so hits, overwrites and evictions are frequent. Both ports idle
// at random, with some phases run back to back.
// ----------------------------------------------------------------------------
module tb;
    import lkv_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_in_word         in_word = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_word        out_word;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    int               fail_count;
    int               pending;
    bit               calm = 1'b0;

    logic [KEY_W-1:0] key_pool [20];
    logic [CFG_W-1:0] cap_plan [10] = '{5'd31, 5'd2, 5'd16, 5'd1, 5'd8,
                                         5'd17, 5'd3, 5'd0, 5'd12, 5'd16};

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    lru_key_value_cache dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    lkv_checker #(.ENTRIES(ENTRIES_DEF)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_word(input logic op, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val);
        int       gap;
        t_in_word w;
        gap = calm ? 0 : $urandom_range(0, 5);
        w.opcode      = op;
        w.lookup_key  = key;
        w.write_value = val;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] c);
        cfg_we   <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin : result_sink
        int stall;
        @(posedge clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : stimulus
        int               cap_eff;
        int               span;
        logic [KEY_W-1:0] k;
        for (int i = 0; i < 20; i++)
            key_pool[i] = $urandom;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full capacity from reset, empty cache
        send_word(OP_GET, 32'h0000_0000, 31'h7FFF_FFFF);
        send_word(OP_PUT, 32'h8000_0000, 31'h0000_0000);
        send_word(OP_PUT, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_word(OP_PUT, 32'hFFFF_FFFF, 31'h2AAA_AAAA);
        send_word(OP_PUT, 32'h0000_0000, 31'h5555_5555);
        send_word(OP_GET, 32'h8000_0000, 31'h7FFF_FFFF);
        send_word(OP_GET, 32'h7FFF_FFFF, 31'h0000_0000);
        send_word(OP_PUT, 32'hFFFF_FFFF, 31'h0000_0001);
        send_word(OP_GET, 32'hFFFF_FFFF, 31'h0000_0000);
        send_word(OP_GET, 32'hAAAA_AAAA, 31'h0000_0000);
        send_word(OP_GET, 32'h0000_0000, 31'h0000_0000);
        drain;

        // zero capacity behaves as one; shrinks a four-entry cache
        write_capacity(5'd0);
        send_word(OP_PUT, 32'h5555_5555, 31'h0000_0003);
        send_word(OP_GET, 32'hFFFF_FFFF, 31'h0000_0000);
        send_word(OP_PUT, 32'hAAAA_AAAA, 31'h1234_5678);
        send_word(OP_GET, 32'h5555_5555, 31'h0000_0000);
        send_word(OP_GET, 32'hAAAA_AAAA, 31'h0000_0000);
        send_word(OP_PUT, 32'hAAAA_AAAA, 31'h7FFF_FFFE);
        send_word(OP_GET, 32'hAAAA_AAAA, 31'h0000_0000);
        drain;

        for (int p = 0; p < 10; p++) begin
            write_capacity(cap_plan[p]);
            calm    = (p % 3 == 2);
            cap_eff = (cap_plan[p] == 0) ? 1 :
                      (cap_plan[p] > ENTRIES_DEF) ? ENTRIES_DEF : cap_plan[p];
            span    = cap_eff + 4;
            for (int r = 0; r < 3; r++)
                key_pool[$urandom_range(0, 19)] = $urandom;
            for (int j = 0; j < 45; j++) begin
                if ($urandom_range(0, 9) == 0)
                    k = $urandom;
                else
                    k = key_pool[$urandom_range(0, span - 1)];
                send_word(1'($urandom_range(0, 1)), k, VAL_W'($urandom));
            end
            drain;
        end

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
